// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define PB_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error(msg);
// Check on every clock edge, reset included.
`define PB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) (prop)) \
		else $error(msg);
`else
`define PB_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define PB_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/core/pbrle_pkg.sv =====
// Types and constants of the run-length decoder.
package pbrle_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned WrW    = 17;
	localparam int unsigned RegIdxW = 2;

	localparam logic [LenW-1:0] ExpectedLenRst = 16'd32000;

	typedef enum logic [RegIdxW-1:0] {
		REG_VARIANT      = 2'd0,
		REG_SOURCE_LEN   = 2'd1,
		REG_EXPECTED_LEN = 2'd2,
		REG_LENGTH_KNOWN = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_RUNVAL  = 2'd1,
		PH_LITERAL = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef struct packed {
		logic            variant;
		logic [LenW-1:0] source_length;
		logic [LenW-1:0] expected_length;
		logic            length_known;
	} cfg_t;

	typedef struct packed {
		logic [ByteW-1:0] source_byte;
		logic             start_of_stream;
	} in_item_t;

	// Handshake between the input register and the decode stage.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} s1_bus_t;

endpackage

// ===== rtl/core/pbrle_if.sv =====
// Channel interfaces: compressed byte input and decoded result output.
interface pbrle_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       start_of_stream;

	modport source (output valid, source_byte, start_of_stream, input ready);
	modport sink   (input valid, source_byte, start_of_stream, output ready);
endinterface

interface pbrle_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  value;
	logic [7:0]  repeat_res;
	logic        done_res;
	logic [15:0] consumed;

	modport source (output valid, value, repeat_res, done_res, consumed, input ready);
	modport sink   (input valid, value, repeat_res, done_res, consumed, output ready);
endinterface

// ===== rtl/core/pbrle_in_reg.sv =====
// Input register stage of the decoder.
module pbrle_in_reg import pbrle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pbrle_src_if.sink    src,
	input  logic         advance,
	output s1_bus_t      s1
);

	logic     valid_s1;
	in_item_t item_s1;

	// Take a new byte when the stage is empty or drains this cycle.
	assign src.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			item_s1.source_byte     <= src.source_byte;
			item_s1.start_of_stream <= src.start_of_stream;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

// ===== rtl/core/pbrle_core.sv =====
// Decode stage: phase machine, counters and result register.
`include "assert_macros.svh"

module pbrle_core import pbrle_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  s1_bus_t       s1,
	output logic          advance,
	pbrle_res_if.source   res
);

	phase_t          phase_q, phase_d, ph_e;
	logic [7:0]      lit_q, lit_d, lit_e;
	logic [15:0]     pos_q, pos_d, pos_e, pos_inc;
	logic [16:0]     wr_q, wr_d, wr_e;

	logic            emit;
	logic [7:0]      emit_value, emit_rep;
	logic            emit_done;
	logic [15:0]     emit_cons;

	logic [7:0]      b;
	logic            is_run;
	logic [8:0]      count9;
	logic [7:0]      count;
	logic [7:0]      lit_dec;
	logic [16:0]     wr_run, wr_lit;

	logic            res_valid_s2;
	logic [7:0]      value_s2, rep_s2;
	logic            done_s2;
	logic [15:0]     cons_s2;

	function automatic logic stop_chk(input logic [16:0] wr, input logic [15:0] pos,
			input cfg_t c);
		logic len_hit;
		logic src_hit;
		len_hit = c.length_known && (wr >= {1'b0, c.expected_length});
		src_hit = ({1'b0, pos} + 17'd2) > {1'b0, c.source_length};
		return len_hit || src_hit;
	endfunction

	function automatic logic [16:0] sat_add(input logic [16:0] wr, input logic [7:0] n);
		logic [17:0] sum;
		sum = {1'b0, wr} + {10'd0, n};
		return sum[17] ? 17'h1FFFF : sum[16:0];
	endfunction

	assign advance = s1.valid && (!res_valid_s2 || res.ready);
	assign b       = s1.item.source_byte;

	// Start of stream clears the state before the byte is taken.
	always_comb begin
		if (s1.item.start_of_stream) begin
			ph_e  = PH_HEADER;
			lit_e = 8'd0;
			pos_e = 16'd0;
			wr_e  = 17'd0;
		end else begin
			ph_e  = phase_q;
			lit_e = lit_q;
			pos_e = pos_q;
			wr_e  = wr_q;
		end
	end

	// Header decode for both variants.
	always_comb begin
		if (!cfg.variant) begin
			is_run = b[7];
			count9 = is_run ? (9'd258 - {1'b0, b}) : ({1'b0, b} + 9'd1);
		end else begin
			is_run = !b[7];
			count9 = is_run ? ({1'b0, b} + 9'd3) : ({1'b0, b} - 9'd127);
		end
		count = count9[7:0];
	end

	assign pos_inc = pos_e + 16'd1;
	assign lit_dec = (lit_e != 8'd0) ? (lit_e - 8'd1) : 8'd0;
	assign wr_run  = sat_add(wr_e, lit_e);
	assign wr_lit  = sat_add(wr_e, 8'd1);

	always_comb begin
		phase_d    = ph_e;
		lit_d      = lit_e;
		pos_d      = pos_e;
		wr_d       = wr_e;
		emit       = 1'b0;
		emit_value = 8'd0;
		emit_rep   = 8'd0;
		emit_done  = 1'b0;
		emit_cons  = 16'd0;
		case (ph_e)
			PH_HEADER: begin
				if (stop_chk(wr_e, pos_e, cfg)) begin
					phase_d   = PH_DONE;
					emit      = 1'b1;
					emit_done = 1'b1;
					emit_cons = pos_e;
				end else if (is_run) begin
					pos_d   = pos_inc;
					lit_d   = count;
					phase_d = PH_RUNVAL;
				end else if (({1'b0, pos_inc} + {9'd0, count}) > {1'b0, cfg.source_length}) begin
					// Literal overrun: leave the header unconsumed.
					phase_d   = PH_DONE;
					emit      = 1'b1;
					emit_done = 1'b1;
					emit_cons = pos_e;
				end else begin
					pos_d   = pos_inc;
					lit_d   = count;
					phase_d = PH_LITERAL;
				end
			end
			PH_RUNVAL: begin
				pos_d      = pos_inc;
				wr_d       = wr_run;
				lit_d      = 8'd0;
				emit       = 1'b1;
				emit_value = b;
				emit_rep   = lit_e;
				emit_done  = stop_chk(wr_run, pos_inc, cfg);
				emit_cons  = emit_done ? pos_inc : 16'd0;
				phase_d    = emit_done ? PH_DONE : PH_HEADER;
			end
			PH_LITERAL: begin
				pos_d      = pos_inc;
				wr_d       = wr_lit;
				lit_d      = lit_dec;
				emit       = 1'b1;
				emit_value = b;
				emit_rep   = 8'd1;
				if (lit_dec == 8'd0) begin
					emit_done = stop_chk(wr_lit, pos_inc, cfg);
					phase_d   = emit_done ? PH_DONE : PH_HEADER;
				end
				emit_cons = emit_done ? pos_inc : 16'd0;
			end
			default: begin
				// Stopped: drop bytes until a new stream starts.
				phase_d = ph_e;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lit_q   <= 8'd0;
			pos_q   <= 16'd0;
			wr_q    <= 17'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			lit_q   <= lit_d;
			pos_q   <= pos_d;
			wr_q    <= wr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= emit;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_s2 <= emit_value;
			rep_s2   <= emit_rep;
			done_s2  <= emit_done;
			cons_s2  <= emit_cons;
		end
	end

	assign res.valid      = res_valid_s2;
	assign res.value      = value_s2;
	assign res.repeat_res = rep_s2;
	assign res.done_res   = done_s2;
	assign res.consumed   = cons_s2;

	`PB_ASSERT_ALWAYS(a_status_only_is_done, clk, (res_valid_s2 && rep_s2 == 8'd0) |-> done_s2, "status-only result without done")
	`PB_ASSERT(a_repeat_in_range, clk, arst_n, res_valid_s2 |-> (rep_s2 <= 8'd130), "repeat count above 130")
	`PB_ASSERT(a_literal_left_nonzero, clk, arst_n, (phase_q == PH_LITERAL) |-> (lit_q != 8'd0), "literal phase with no bytes left")
	`PB_ASSERT(a_done_enters_stop, clk, arst_n, (advance && emit && emit_done) |=> (phase_q == PH_DONE), "done result without stop phase")
	`PB_ASSERT(a_not_done_no_count, clk, arst_n, (res_valid_s2 && !done_s2) |-> (cons_s2 == 16'd0), "consumed count on a result that is not final")

endmodule

// ===== rtl/core/packbits_variant_rle_decoder.sv =====
// Top level of the PackBits-style run-length decoder.
//
// Usage:
//   src carries the compressed stream, one byte per transaction; set
//   start_of_stream on the first byte of a stream to clear the position,
//   output count and phase. res carries one decoded item per transaction:
//   value repeated repeat_res times (1 to 130), or a status-only item with
//   repeat_res 0. done_res marks the final item of a stream and then
//   consumed gives the number of source bytes taken. A header byte that
//   opens a run or literal, and bytes after the stop, give no transaction on res.
//   Write the variant, source length, expected length and length-known
//   registers through cfg_wr_en/cfg_index/cfg_wdata while the block is idle.
// Path: an accepted byte passes the input register, then the decode stage
//   that loads the result register.
// Throughput: one byte per cycle while res is not held; the phase update and
//   compares fit in the single decode stage between the two registers.
// Reset: arst_n clears the phase machine, the counters, both stage valids
//   and the registers to their defaults (expected length 32000, known).
// Stall: while res is held, the result register holds and the input stage
//   takes one more byte only if it is empty, then src.ready drops until res drains.
module packbits_variant_rle_decoder import pbrle_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [RegIdxW-1:0]   cfg_index,
	input  logic [LenW-1:0]      cfg_wdata,
	pbrle_src_if.sink            src,
	pbrle_res_if.source          res
);

	cfg_t    cfg_q;
	s1_bus_t s1;
	logic    advance;

	// Configuration registers; every index is a defined register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variant         <= 1'b0;
			cfg_q.source_length   <= '0;
			cfg_q.expected_length <= ExpectedLenRst;
			cfg_q.length_known    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_VARIANT:      cfg_q.variant         <= cfg_wdata[0];
				REG_SOURCE_LEN:   cfg_q.source_length   <= cfg_wdata;
				REG_EXPECTED_LEN: cfg_q.expected_length <= cfg_wdata;
				REG_LENGTH_KNOWN: cfg_q.length_known    <= cfg_wdata[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Hold the incoming byte for the decode stage.
	pbrle_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.src     (src),
		.advance (advance),
		.s1      (s1)
	);

	// Advance the phase machine and load the result register.
	pbrle_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s1      (s1),
		.advance (advance),
		.res     (res)
	);

endmodule

// ===== verif/packbits_variant_rle_decoder_tb.sv =====
// Self-checking testbench of the PackBits-style run-length decoder: directed and random streams.
`timescale 1ns / 1ps

module packbits_variant_rle_decoder_tb import pbrle_pkg::*; ();

	// A result passes the input and result registers after its byte; a header byte
	// that opens an item gives none, so let the pipeline settle before touching the registers.
	localparam int unsigned SETTLE_CYCLES = 6;
	// Slowest run: ~1650 bytes, each with the longest source gap and the longest
	// result stall, plus register writes; taken about four times.
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned BYTE_TARGET   = 1600;
	localparam int unsigned WRITTEN_MAX   = (1 << WrW) - 1;

	typedef struct packed {
		logic [7:0]      value;
		logic [7:0]      repeat_res;
		logic            done_res;
		logic [LenW-1:0] consumed;
	} dec_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [RegIdxW-1:0] cfg_index;
	logic [LenW-1:0]    cfg_wdata;

	pbrle_src_if src_ch();
	pbrle_res_if res_ch();

	packbits_variant_rle_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src       (src_ch),
		.res       (res_ch)
	);

	// Register copy, kept in step with every write.
	logic            cfg_variant = 1'b0;
	logic [LenW-1:0] cfg_src_len = '0;
	logic [LenW-1:0] cfg_exp_len = ExpectedLenRst;
	logic            cfg_known   = 1'b1;

	// Decoder state as the predictor sees it.
	phase_t          dec_phase   = PH_HEADER;
	logic [7:0]      dec_left    = '0;
	logic [LenW-1:0] dec_pos     = '0;
	logic [WrW-1:0]  dec_written = '0;
	logic [LenW-1:0] dec_hdr_pos = '0;

	in_item_t    src_pending[$];  // bytes waiting for the source driver
	dec_res_t    results_due[$];  // decoded results not yet seen on res

	bit          byte_taken;
	bit          calm;            // no idling on either side while set
	int unsigned src_gap;
	int unsigned sink_stall;
	int unsigned cycle_cnt;
	int unsigned err_cnt;
	int unsigned sent_total;

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Stop holds once the output length is reached (when known) or when
	// fewer than two source bytes are left.
	function automatic bit stop_reached();
		if (cfg_known && dec_written >= {1'b0, cfg_exp_len})
			return 1'b1;
		return (32'(dec_pos) + 32'd2) > 32'(cfg_src_len);
	endfunction

	// Saturate the output count instead of wrapping.
	function automatic void add_written(int unsigned n);
		int unsigned sum;
		sum = 32'(dec_written) + n;
		dec_written = (sum > WRITTEN_MAX) ? WrW'(WRITTEN_MAX) : WrW'(sum);
	endfunction

	// Consumed only carries a count on the final result of a stream.
	function automatic void queue_result(logic [7:0] v, logic [7:0] rep, logic done,
			logic [LenW-1:0] cons);
		dec_res_t r;
		r.value      = v;
		r.repeat_res = rep;
		r.done_res   = done;
		r.consumed   = done ? cons : '0;
		results_due.push_back(r);
	endfunction

	// Advance the decoder by one accepted source byte.
	function automatic void decode_byte(logic [7:0] b, logic sos);
		bit          is_run;
		bit          stop;
		int unsigned cnt;
		if (sos) begin
			dec_phase   = PH_HEADER;
			dec_left    = '0;
			dec_pos     = '0;
			dec_written = '0;
			dec_hdr_pos = '0;
		end
		case (dec_phase)
			PH_HEADER: begin
				if (stop_reached()) begin
					// Stop already holds: drop the header, report status only.
					dec_phase = PH_DONE;
					queue_result(8'd0, 8'd0, 1'b1, dec_pos);
				end else begin
					if (!cfg_variant) begin
						is_run = (b >= 8'd128);
						cnt    = is_run ? 258 - 32'(b) : 32'(b) + 1;
					end else begin
						is_run = (b <= 8'd127);
						cnt    = is_run ? 32'(b) + 3 : 32'(b) - 127;
					end
					dec_hdr_pos = dec_pos;
					dec_pos     = dec_pos + 16'd1;
					if (is_run) begin
						dec_left  = 8'(cnt);
						dec_phase = PH_RUNVAL;
					end else if (32'(dec_pos) + cnt > 32'(cfg_src_len)) begin
						// Literal would overrun the source: give the header back.
						dec_pos   = dec_hdr_pos;
						dec_phase = PH_DONE;
						queue_result(8'd0, 8'd0, 1'b1, dec_hdr_pos);
					end else begin
						dec_left  = 8'(cnt);
						dec_phase = PH_LITERAL;
					end
				end
			end
			PH_RUNVAL: begin
				cnt      = 32'(dec_left);
				dec_pos  = dec_pos + 16'd1;
				add_written(cnt);
				dec_left = '0;
				stop     = stop_reached();
				dec_phase = stop ? PH_DONE : PH_HEADER;
				queue_result(b, 8'(cnt), stop, dec_pos);
			end
			PH_LITERAL: begin
				dec_pos = dec_pos + 16'd1;
				add_written(1);
				if (dec_left != 8'd0)
					dec_left = dec_left - 8'd1;
				stop = 1'b0;
				if (dec_left == 8'd0) begin
					stop      = stop_reached();
					dec_phase = stop ? PH_DONE : PH_HEADER;
				end
				queue_result(b, 8'd1, stop, dec_pos);
			end
			default: ;  // stopped: ignore until the next start of stream
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Source driver: drive at the falling edge, hold until the transaction
	// completes, then advance with a random gap.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_src
		in_item_t nxt;
		if (!arst_n) begin
			src_ch.valid <= 1'b0;
		end else if (!src_ch.valid || byte_taken) begin
			if (src_gap > 0) begin
				src_gap--;
				src_ch.valid <= 1'b0;
			end else if (src_pending.size() != 0) begin
				nxt = src_pending.pop_front();
				src_ch.valid           <= 1'b1;
				src_ch.source_byte     <= nxt.source_byte;
				src_ch.start_of_stream <= nxt.start_of_stream;
				src_gap = idle_len();
			end else begin
				src_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: stall at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			sink_stall = idle_len();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample at the rising edge, check results against the oldest
	// prediction, then predict from the accepted byte.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : monitor
		dec_res_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			cycle_cnt++;
			byte_taken <= src_ch.valid && src_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: value %0d repeat %0d done %0d consumed %0d",
						res_ch.value, res_ch.repeat_res, res_ch.done_res, res_ch.consumed);
					err_cnt++;
				end else begin
					want = results_due.pop_front();
					check_field("value", 32'(want.value), 32'(res_ch.value));
					check_field("repeat_res", 32'(want.repeat_res),
						32'(res_ch.repeat_res));
					check_field("done_res", 32'(want.done_res), 32'(res_ch.done_res));
					check_field("consumed", 32'(want.consumed), 32'(res_ch.consumed));
				end
			end
			if (src_ch.valid && src_ch.ready)
				decode_byte(src_ch.source_byte, src_ch.start_of_stream);
		end
	end

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Hold until every byte is taken and every result has come; return on a
	// rising edge so that new bytes are queued away from the driver's edge.
	task automatic wait_drained();
		while (src_pending.size() != 0 || src_ch.valid || results_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [LenW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_VARIANT:      cfg_variant = data[0];
			REG_SOURCE_LEN:   cfg_src_len = data;
			REG_EXPECTED_LEN: cfg_exp_len = data;
			REG_LENGTH_KNOWN: cfg_known   = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Drain, let a header still in flight settle, then write the registers
	// selected by mask (bit i for register i).
	task automatic load_cfg(logic [3:0] mask, logic v, logic [LenW-1:0] slen,
			logic [LenW-1:0] elen, logic known);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mask[REG_VARIANT])      write_reg(REG_VARIANT, LenW'(v));
		if (mask[REG_SOURCE_LEN])   write_reg(REG_SOURCE_LEN, slen);
		if (mask[REG_EXPECTED_LEN]) write_reg(REG_EXPECTED_LEN, elen);
		if (mask[REG_LENGTH_KNOWN]) write_reg(REG_LENGTH_KNOWN, LenW'(known));
		@(posedge clk);
	endtask

	// Queue a stream; with pause, hold the second half back until all
	// results of the first half have come.
	task automatic send(ref in_item_t s[$], input bit pause);
		int unsigned half;
		half = pause ? s.size() / 2 : s.size();
		foreach (s[i]) begin
			if (i == half)
				wait_drained();
			src_pending.push_back(s[i]);
		end
		sent_total += s.size();
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		in_item_t        stream[$];
		in_item_t        it;
		int unsigned     n;
		int unsigned     cnt;
		int unsigned     decoded;
		int unsigned     body_len;
		int unsigned     r;
		int unsigned     stream_no;
		logic [7:0]      hdr;
		logic            v;
		logic [3:0]      mask;
		logic [LenW-1:0] slen;
		logic [LenW-1:0] elen;
		logic            known;

		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = REG_VARIANT;
		cfg_wdata              = '0;
		src_ch.valid           = 1'b0;
		src_ch.source_byte     = '0;
		src_ch.start_of_stream = 1'b0;
		res_ch.ready           = 1'b0;
		calm                   = 1'b0;
		src_gap                = 0;
		sink_stall             = 0;
		cycle_cnt              = 0;
		err_cnt                = 0;
		sent_total             = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at reset: an empty source stops on the very first header.
		stream = '{{8'h00, 1'b1}};
		send(stream, 1'b0);

		// High-header runs at both ends (130 and 3 copies), a one-byte
		// literal and a three-byte literal; the source ends exactly there.
		load_cfg(4'b1111, 1'b0, 16'd10, 16'd65535, 1'b0);
		stream = '{{8'h80, 1'b1}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0},
			{8'h00, 1'b0}, {8'h55, 1'b0}, {8'h02, 1'b0}, {8'h01, 1'b0},
			{8'h02, 1'b0}, {8'h03, 1'b0}};
		send(stream, 1'b0);

		// Low-header runs at both ends, a one-byte literal, then a 128-byte
		// literal that would overrun the source; the byte after it is ignored.
		load_cfg(4'b0011, 1'b1, 16'd20, 16'd0, 1'b0);
		stream = '{{8'h7F, 1'b1}, {8'h80, 1'b0}, {8'h00, 1'b0}, {8'h7F, 1'b0},
			{8'h80, 1'b0}, {8'h11, 1'b0}, {8'hFF, 1'b0}, {8'h33, 1'b0}};
		send(stream, 1'b0);

		// Stop on reaching the expected output length after a run.
		load_cfg(4'b1111, 1'b0, 16'd100, 16'd5, 1'b1);
		stream = '{{8'hFD, 1'b1}, {8'h42, 1'b0}};
		send(stream, 1'b0);

		// Expected length zero: stop before the first header is taken.
		load_cfg(4'b0100, 1'b0, 16'd0, 16'd0, 1'b0);
		stream = '{{8'h00, 1'b1}};
		send(stream, 1'b0);

		// Random streams: mostly well-formed items with random content, the
		// rest noise; trailing bytes after the stop check that they are dropped.
		stream_no = 0;
		while (sent_total < BYTE_TARGET) begin
			stream.delete();
			decoded = 0;
			v       = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					it.source_byte     = 8'($urandom_range(0, 255));
					it.start_of_stream = (i == 0) || ($urandom_range(0, 9) == 0);
					stream.push_back(it);
				end
				slen  = LenW'($urandom_range(0, 40));
				elen  = LenW'($urandom_range(0, 60));
				known = 1'($urandom_range(0, 1));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					it.start_of_stream = 1'b0;
					if ($urandom_range(0, 1) == 1) begin
						hdr     = v ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
						decoded += v ? 32'(hdr) + 3 : 258 - 32'(hdr);
						it.source_byte = hdr;
						stream.push_back(it);
						it.source_byte = 8'($urandom_range(0, 255));
						stream.push_back(it);
					end else begin
						cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128)
							: $urandom_range(1, 8);
						hdr     = v ? 8'(cnt + 127) : 8'(cnt - 1);
						decoded += cnt;
						it.source_byte = hdr;
						stream.push_back(it);
						for (int k = 0; k < cnt; k++) begin
							it.source_byte = 8'($urandom_range(0, 255));
							stream.push_back(it);
						end
					end
				end
				stream[0].start_of_stream = 1'b1;
				// Break the sequence now and then with a restart in the middle.
				if (stream.size() > 2 && $urandom_range(0, 9) == 0)
					stream[$urandom_range(1, stream.size() - 1)].start_of_stream = 1'b1;

				body_len = stream.size();
				r = $urandom_range(0, 19);
				if (r == 0)
					slen = '0;
				else if (r == 1)
					slen = '1;
				else if (r < 12)
					slen = LenW'(body_len);
				else if (r < 16)
					slen = LenW'($urandom_range(0, body_len));
				else
					slen = LenW'(body_len + $urandom_range(1, 20));

				r = $urandom_range(0, 19);
				if (r == 0)
					elen = '0;
				else if (r == 1)
					elen = '1;
				else if (r < 10)
					elen = LenW'(decoded);
				else if (r < 16)
					elen = LenW'($urandom_range(0, decoded));
				else
					elen = ExpectedLenRst;
				known = ($urandom_range(0, 9) < 7);

				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					it.source_byte     = 8'($urandom_range(0, 255));
					it.start_of_stream = 1'b0;
					stream.push_back(it);
				end
			end

			mask = 4'($urandom_range(0, 15)) | 4'b0011;
			load_cfg(mask, v, slen, elen, known);
			calm = ($urandom_range(0, 5) == 0);
			send(stream, (stream_no == 0) || ($urandom_range(0, 9) == 0));
			stream_no++;
		end

		// Drain, let the pipeline settle, then report.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0 && results_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== packbits_variant_rle_decoder.f =====
+incdir+rtl/core
rtl/core/pbrle_pkg.sv
rtl/core/pbrle_if.sv
rtl/core/pbrle_in_reg.sv
rtl/core/pbrle_core.sv
rtl/core/packbits_variant_rle_decoder.sv
verif/packbits_variant_rle_decoder_tb.sv
